// ----- src/sorted_run_kway_merger_assert.svh -----
// Assertion macros used by the merger datapath
`ifndef SORTED_RUN_KWAY_MERGER_ASSERT_SVH
`define SORTED_RUN_KWAY_MERGER_ASSERT_SVH
`ifndef SYNTH
`define SKM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SKM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define SKM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SKM_ASSERT_ALWAYS(lbl, prop, msg)
`define SKM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SKM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/skm_pkg.sv -----
// Shared types and constants of the k-way merger
`timescale 1ns / 1ps
`default_nettype none
package skm_pkg;

	localparam int RUN_W    = 4;
	localparam int RUN_SPAN = 16;
	localparam int CNT_W    = 5;
	localparam int KEY_W    = 64;
	localparam int ADDR_W   = 64;
	localparam int MOD_W    = 32;
	localparam int FLG_W    = 8;

	// request bus layout: run, key, address, module, flags
	localparam int IN_KEY_LSB  = RUN_W;
	localparam int IN_ADDR_LSB = IN_KEY_LSB + KEY_W;
	localparam int IN_MOD_LSB  = IN_ADDR_LSB + ADDR_W;
	localparam int IN_FLG_LSB  = IN_MOD_LSB + MOD_W;
	localparam int IN_FIELDS_W = IN_FLG_LSB + FLG_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// result bus layout: key, address, module, flags, refill run
	localparam int OUT_FIELDS_W = KEY_W + ADDR_W + MOD_W + FLG_W + RUN_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	localparam int KIND_W = 2;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_RUNS = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENTRY    = 2'd0,
		KIND_FINISHED = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_ERR,
		ST_EMIT_FIN,
		ST_EMIT_ENT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] addr;
		logic [MOD_W-1:0]  module_id;
		logic [FLG_W-1:0]  flags;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_step;
		logic load_err;
		logic load_fin;
		logic load_entry;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic rdy;
		logic anyh;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/skm_ctrl.sv -----
// Controller state machine of the k-way merger
`timescale 1ns / 1ps
`default_nettype none
module skm_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output skm_pkg::cmd_t    cmd,
	input  wire skm_pkg::sts_t sts
);
	import skm_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.err)        state_nx = ST_EMIT_ERR;
				else if (!sts.rdy)  state_nx = ST_IDLE;
				else if (!sts.anyh) state_nx = ST_EMIT_FIN;
				else                state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nx = ST_EMIT_ENT;
			end
			ST_EMIT_ERR, ST_EMIT_FIN, ST_EMIT_ENT: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECIDE: begin
				cmd.scan_start = !sts.err && sts.rdy && sts.anyh;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_EMIT_ERR: begin
				cmd.load_err = sts.out_free;
			end
			ST_EMIT_FIN: begin
				cmd.load_fin = sts.out_free;
			end
			ST_EMIT_ENT: begin
				cmd.load_entry = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/skm_dpath.sv -----
// Datapath of the k-way merger: head store, run flags, min scan, result register
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_run_kway_merger_assert.svh"
module skm_dpath #(
	parameter int RUNS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [skm_pkg::CNT_W-1:0]         active_runs,
	input  wire logic                              in_op,
	input  wire logic [skm_pkg::IN_DATA_W-1:0]     in_data,
	input  wire skm_pkg::cmd_t                     cmd,
	output skm_pkg::sts_t                          sts,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [skm_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic [skm_pkg::KIND_W-1:0]             m_tuser
);
	import skm_pkg::*;

	localparam int CAP = (RUNS < RUN_SPAN) ? RUNS : RUN_SPAN;
	localparam int AW  = $clog2(CAP);
	localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);

	logic [CNT_W-1:0] n_eff;
	logic [RUN_W-1:0] in_run;
	logic [AW-1:0]    in_idx;
	entry_t           in_ent;
	logic             in_range, err_c, rdy_c, anyh_c;
	logic [CAP-1:0]   pres_nx, fin_nx;

	logic [CAP-1:0]   present_q, finished_q;
	logic             err_q, rdy_q, anyh_q;
	logic [CNT_W-1:0] idx_q;

	entry_t           mem [CAP];
	entry_t           rd_ent_s1;
	logic             rd_v_s1, rd_pres_s1;
	logic [AW-1:0]    rd_idx_s1;

	logic             best_v_q;
	entry_t           best_q;
	logic [AW-1:0]    best_idx_q;
	logic             take;

	logic             out_valid_q;
	kind_t            out_kind_q;
	entry_t           out_ent_q;
	logic [RUN_W-1:0] out_refill_q;
	logic             out_free;

	// zero acts as one run, large counts clamp to the storage depth
	always_comb begin
		if (active_runs == '0)       n_eff = CNT_W'(1);
		else if (active_runs > CAP_N) n_eff = CAP_N;
		else                          n_eff = active_runs;
	end

	assign in_run           = in_data[RUN_W-1:0];
	assign in_idx           = in_run[AW-1:0];
	assign in_ent.key       = in_data[IN_KEY_LSB +: KEY_W];
	assign in_ent.addr      = in_data[IN_ADDR_LSB +: ADDR_W];
	assign in_ent.module_id = in_data[IN_MOD_LSB +: MOD_W];
	assign in_ent.flags     = in_data[IN_FLG_LSB +: FLG_W];

	assign in_range = {1'b0, in_run} < n_eff;
	assign err_c    = !in_range || present_q[in_idx] || finished_q[in_idx];

	always_comb begin
		pres_nx = present_q;
		fin_nx  = finished_q;
		if (!err_c) begin
			if (in_op) fin_nx[in_idx]  = 1'b1;
			else       pres_nx[in_idx] = 1'b1;
		end
	end

	// every active run must hold a head or be done before a pop
	always_comb begin
		rdy_c  = 1'b1;
		anyh_c = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			if (CNT_W'(i) < n_eff) begin
				if (!pres_nx[i] && !fin_nx[i]) rdy_c = 1'b0;
				if (pres_nx[i]) anyh_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			finished_q <= '0;
			err_q      <= 1'b0;
			rdy_q      <= 1'b0;
			anyh_q     <= 1'b0;
		end else begin
			if (cmd.capture) begin
				err_q  <= err_c;
				rdy_q  <= rdy_c;
				anyh_q <= anyh_c;
			end
			if (cmd.capture && !err_c) begin
				present_q  <= pres_nx;
				finished_q <= fin_nx;
			end else if (cmd.load_fin) begin
				present_q  <= '0;
				finished_q <= '0;
			end else if (cmd.load_entry) begin
				present_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// head store
	always_ff @(posedge clk) begin
		if (cmd.capture && !err_c && !in_op) mem[in_idx] <= in_ent;
		rd_ent_s1 <= mem[idx_q[AW-1:0]];
		rd_idx_s1 <= idx_q[AW-1:0];
	end

	// scan: one head read per cycle, compared in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rd_v_s1    <= 1'b0;
			rd_pres_s1 <= 1'b0;
			best_v_q   <= 1'b0;
		end else begin
			rd_v_s1    <= cmd.scan_step;
			rd_pres_s1 <= present_q[idx_q[AW-1:0]];
			if (cmd.scan_start)     idx_q <= '0;
			else if (cmd.scan_step) idx_q <= idx_q + CNT_W'(1);
			if (cmd.scan_start) best_v_q <= 1'b0;
			else if (take)      best_v_q <= 1'b1;
		end
	end

	// strict less-than keeps the lowest run on equal keys
	assign take = rd_v_s1 && rd_pres_s1 && (!best_v_q || rd_ent_s1.key < best_q.key);

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= rd_ent_s1;
			best_idx_q <= rd_idx_s1;
		end
	end

	// result register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_fin || cmd.load_entry) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_kind_q   <= KIND_ERROR;
			out_ent_q    <= '0;
			out_refill_q <= '0;
		end else if (cmd.load_fin) begin
			out_kind_q   <= KIND_FINISHED;
			out_ent_q    <= '0;
			out_refill_q <= '0;
		end else if (cmd.load_entry) begin
			out_kind_q   <= KIND_ENTRY;
			out_ent_q    <= best_q;
			out_refill_q <= RUN_W'(best_idx_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_refill_q, out_ent_q.flags,
		out_ent_q.module_id, out_ent_q.addr, out_ent_q.key};

	assign sts.err       = err_q;
	assign sts.rdy       = rdy_q;
	assign sts.anyh      = anyh_q;
	assign sts.scan_last = (idx_q == n_eff - CNT_W'(1));
	assign sts.out_free  = out_free;

	`SKM_ASSERT_ALWAYS(a_head_xor_done, (present_q & finished_q) == '0, "run both holds a head and is done")
	`SKM_ASSERT_IMPLY(a_pop_has_best, cmd.load_entry, best_v_q, "pop without a selected head")
	`SKM_ASSERT_NEXT(a_fin_clears, cmd.load_fin, (present_q == '0) && (finished_q == '0), "finish left run state")
	`SKM_ASSERT_IMPLY(a_no_overwrite, cmd.load_err || cmd.load_fin || cmd.load_entry, !out_valid_q || m_tready, "result register overwritten")

endmodule
`default_nettype wire

// ----- src/sorted_run_kway_merger.sv -----
// Top level of the k-way merger: config register, controller and datapath
`timescale 1ns / 1ps
`default_nettype none
// Merges up to min(RUNS,16) ascending runs of index entries into one ascending stream.
// Input stream: each request is either the next entry of a run (tuser = 0) or an
//   end-of-run mark (tuser = 1). The feeder keeps one entry in flight per run.
// Output stream: tuser gives the kind: merged entry, merge finished, or protocol
//   error. A merged entry names the run to feed next in refill_run.
// APB register 0 (active_runs) sets how many runs take part; write it only while
//   the block is idle. It resets to 1.
// Per request, n = effective run count:
//   request that leaves some active run empty: no result;
//   error or finished result: loaded into the result register after the decide step;
//   merged entry: the min search reads one head per cycle from the head store
//   across all n active runs, then the smallest head is loaded as the result.
// One request is processed at a time. The result sits in an output register, so
// the next request is taken while it waits; a stalled receiver only blocks the
// block once a new result has to be loaded.
// Reset clears all run flags and the output valid; head entries need no clearing,
// they are read only once written.
module sorted_run_kway_merger #(
	parameter int RUNS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// request stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [3:0] run, [67:4] pointer_value, [131:68] source_address,
	// [163:132] module_number, [171:164] entry_flags, [175:172] zero
	input  wire logic [175:0] s_axis_tdata,
	// [0] op
	input  wire logic         s_axis_tuser,
	// result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [63:0] out_pointer_value, [127:64] out_source_address,
	// [159:128] out_module_number, [167:160] out_entry_flags,
	// [171:168] refill_run, [175:172] zero
	output logic [175:0]      m_axis_tdata,
	// [1:0] kind
	output logic [1:0]        m_axis_tuser
);
	import skm_pkg::*;

	logic [CNT_W-1:0]     active_runs_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	cmd_t                 cmd;
	sts_t                 sts;

	// register index comes from the word address
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_ACTIVE_RUNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_runs_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			active_runs_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ACTIVE_RUNS) prdata = {{(32 - CNT_W){1'b0}}, active_runs_q};
	end

	// controller: sequences capture, decide, head scan and result load
	skm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: run flags, head store, min tracker, result register
	skm_dpath #(
		.RUNS (RUNS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_runs (active_runs_q),
		.in_op       (s_axis_tuser),
		.in_data     (s_axis_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the k-way sorted run merger: stream stimulus, APB setup, scoreboard
`timescale 1ns / 1ps

module tb;
	import skm_pkg::*;

	localparam int   RUNS        = 16;
	localparam logic OP_ENTRY    = 1'b0;  // next entry of a run
	localparam logic OP_END      = 1'b1;  // run has ended
	localparam int   SETTLE_CYC  = RUN_SPAN + 16;  // above the worst pop latency
	localparam int   HOLD_CYC    = 300;            // long receiver hold-off
	localparam int   STALL_LIMIT = 4000;           // cycles with no transfer on either stream
	localparam int   PHASE_REQS  = 178;
	localparam int   SHOW_MAX    = 10;
	localparam int   IN_PAD_W    = IN_DATA_W - IN_FIELDS_W;

	// request word, lowest field last
	typedef struct packed {
		logic [IN_PAD_W-1:0] pad;
		logic [FLG_W-1:0]    flags;
		logic [MOD_W-1:0]    mod_id;
		logic [ADDR_W-1:0]   addr;
		logic [KEY_W-1:0]    key;
		logic [RUN_W-1:0]    run;
	} req_word_t;

	// result word, lowest field last
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [RUN_W-1:0]     refill;
		logic [FLG_W-1:0]     flags;
		logic [MOD_W-1:0]     mod_id;
		logic [ADDR_W-1:0]    addr;
		logic [KEY_W-1:0]     key;
	} pop_word_t;

	typedef struct packed {
		kind_t     kind;
		pop_word_t word;
	} pop_t;

	// Tracks the head store and run flags, and queues the result each request causes.
	class kway_merge_checker;
		entry_t           head [RUN_SPAN];
		bit               held [RUN_SPAN];
		bit               ended[RUN_SPAN];
		logic [CNT_W-1:0] run_cfg;
		pop_t             due_pops[$];
		int               requests;
		int               fails;

		function new();
			clear_runs();
			run_cfg  = CNT_W'(1);
			requests = 0;
			fails    = 0;
		endfunction

		function void clear_runs();
			for (int i = 0; i < RUN_SPAN; i++) begin
				head[i]  = '0;
				held[i]  = 1'b0;
				ended[i] = 1'b0;
			end
		endfunction

		// 0 acts as 1, large values clamp to the run span and to RUNS
		function int live_runs();
			int n;
			n = int'(run_cfg);
			if (n == 0)
				n = 1;
			if (n > RUN_SPAN)
				n = RUN_SPAN;
			if (n > RUNS)
				n = RUNS;
			return n;
		endfunction

		function bit idle_merge();
			for (int i = 0; i < RUN_SPAN; i++)
				if (held[i] || ended[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void take_request(logic op, req_word_t w);
			pop_t p;
			int   n;
			int   best;
			bit   found;
			n = live_runs();
			p = '0;
			requests++;
			// bad run, ended run or a head still held: error, state untouched
			if (w.run >= n || ended[w.run] || held[w.run]) begin
				p.kind = KIND_ERROR;
				due_pops = {due_pops, p};
				return;
			end
			if (op == OP_ENTRY) begin
				head[w.run] = {w.key, w.addr, w.mod_id, w.flags};
				held[w.run] = 1'b1;
			end else begin
				ended[w.run] = 1'b1;
			end
			for (int i = 0; i < n; i++)
				if (!held[i] && !ended[i])
					return;
			found = 1'b0;
			best  = 0;
			// strict less-than keeps the lowest run on equal keys
			for (int i = 0; i < n; i++) begin
				if (held[i] && (!found || head[i].key < head[best].key)) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				clear_runs();
				p.kind = KIND_FINISHED;
			end else begin
				held[best]    = 1'b0;
				p.kind        = KIND_ENTRY;
				p.word.key    = head[best].key;
				p.word.addr   = head[best].addr;
				p.word.mod_id = head[best].module_id;
				p.word.flags  = head[best].flags;
				p.word.refill = best[RUN_W-1:0];
			end
			due_pops = {due_pops, p};
		endfunction

		function void check_pop(logic [KIND_W-1:0] kind, pop_word_t got);
			pop_t want;
			if (due_pops.size() == 0) begin
				fails++;
				if (fails <= SHOW_MAX)
					$display("unexpected result: kind %0d data %h", kind, got);
				return;
			end
			want = due_pops.pop_front();
			if (kind !== want.kind || got.key !== want.word.key
					|| got.addr !== want.word.addr || got.mod_id !== want.word.mod_id
					|| got.flags !== want.word.flags || got.refill !== want.word.refill
					|| got.pad !== '0) begin
				fails++;
				if (fails <= SHOW_MAX) begin
					$display("result mismatch at %0t (expected / actual):", $realtime);
					$display("  kind %0d / %0d  refill %0d / %0d  flags %h / %h  pad %h",
						want.kind, kind, want.word.refill, got.refill,
						want.word.flags, got.flags, got.pad);
					$display("  key %h / %h  addr %h / %h  module %h / %h",
						want.word.key, got.key, want.word.addr, got.addr,
						want.word.mod_id, got.mod_id);
				end
			end
		endfunction

		function void close_out();
			if (due_pops.size() != 0) begin
				$display("results never delivered: %0d", due_pops.size());
				fails += due_pops.size();
			end
		endfunction
	endclass

	// clock, reset and DUT inputs, all known from time zero
	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         psel          = 1'b0;
	logic         penable       = 1'b0;
	logic         pwrite        = 1'b0;
	logic [2:0]   paddr         = '0;
	logic [31:0]  pwdata        = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata  = '0;
	logic         s_axis_tuser  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [175:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	kway_merge_checker chk;

	// idling mix, pressure control
	int src_idle   = 16;
	int sink_idle  = 54;
	int phase      = 0;
	int hold_from  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int quiet      = 0;

	// per-run key streams for well-formed merges
	logic [KEY_W-1:0] key_next[RUN_SPAN];
	bit               tight;

	sorted_run_kway_merger #(.RUNS(RUNS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [3:0] run, [67:4] key, [131:68] addr, [163:132] module, [171:164] flags
		.s_axis_tuser  (s_axis_tuser),   // [0] op
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [63:0] key, [127:64] addr, [159:128] module, [167:160] flags, [171:168] refill
		.m_axis_tuser  (m_axis_tuser)    // [1:0] kind
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls per phase; once in the last phase it drops ready for a
	// hold-off set by HOLD_CYC while the sender keeps pushing, so the block backs up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (phase == 2 && !hold_done && chk.requests >= hold_from) begin
			hold_done     <= 1'b1;
			hold_left     <= HOLD_CYC;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// result side: every accepted result goes against the oldest expectation
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			chk.check_pop(m_axis_tuser, m_axis_tdata);
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic req_word_t pack_req(logic [RUN_W-1:0] run, logic [KEY_W-1:0] key,
			logic [ADDR_W-1:0] addr, logic [MOD_W-1:0] mod_id, logic [FLG_W-1:0] flags);
		req_word_t w;
		w        = '0;
		w.run    = run;
		w.key    = key;
		w.addr   = addr;
		w.mod_id = mod_id;
		w.flags  = flags;
		return w;
	endfunction

	// new key streams: tight mode makes equal keys across runs common
	function automatic void reseed_keys();
		tight = 1'($urandom_range(1));
		for (int r = 0; r < RUN_SPAN; r++)
			key_next[r] = tight ? KEY_W'($urandom_range(3))
				: {$urandom, $urandom} >> $urandom_range(8, 1);
	endfunction

	function automatic logic [31:0] pick_runs();
		case ($urandom_range(9))
			0: return RUNS;
			1: return 31;
			2: return 0;
			3: return $urandom_range(30, 17);
			default: return $urandom_range(6, 1);
		endcase
	endfunction

	// Mostly the next request of a well-formed merge (fill an empty run with
	// its next key, or close it); about one in ten is noise on any run.
	task automatic make_request(output logic op, output req_word_t w);
		int n;
		int open_runs[$];
		n = chk.live_runs();
		for (int i = 0; i < n; i++)
			if (!chk.held[i] && !chk.ended[i])
				open_runs = {open_runs, i};
		w = pack_req('0, '0, {$urandom, $urandom}, $urandom, FLG_W'($urandom_range(255)));
		if (open_runs.size() == 0 || $urandom_range(99) < 10) begin
			op    = 1'($urandom_range(1));
			w.run = $urandom_range(1) ? RUN_W'($urandom_range(RUN_SPAN - 1))
				: RUN_W'($urandom_range(n - 1));
			w.key = {$urandom, $urandom};
		end else begin
			w.run = RUN_W'(open_runs[$urandom_range(open_runs.size() - 1)]);
			op    = ($urandom_range(5) == 0) ? OP_END : OP_ENTRY;
			w.key = key_next[w.run];
			key_next[w.run] += tight ? KEY_W'($urandom_range(3))
				: {$urandom, $urandom} >> $urandom_range(63, 10);
		end
	endtask

	// offer one request, with random gaps before it; scoreboard notes it on accept
	task automatic put_request(input logic op, input req_word_t w);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		chk.take_request(op, w);
	endtask

	// wait for all results, then let a request with no result finish too
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (chk.due_pops.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * idx);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_ACTIVE_RUNS)
			chk.run_cfg = val[CNT_W-1:0];
	endtask

	task automatic set_runs(input logic [31:0] val);
		settle();
		write_reg(REG_ACTIVE_RUNS, val);
		reseed_keys();
	endtask

	initial begin
		logic        op;
		req_word_t   w;
		logic [31:0] cfg_due;
		bit          cfg_pending;

		chk = new();
		reseed_keys();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one run after reset, all-ones entry, bad run, finish
		put_request(OP_ENTRY, pack_req(0, '1, '1, '1, '1));
		put_request(OP_ENTRY, pack_req(1, 1, 2, 3, 4));
		put_request(OP_END, pack_req(0, 0, 0, 0, 0));
		// three runs: held head, equal keys, ended run, run out of range, zero key
		set_runs(3);
		put_request(OP_ENTRY, pack_req(0, 5, 0, 0, 0));
		put_request(OP_ENTRY, pack_req(0, 6, 1, 1, 1));
		put_request(OP_ENTRY, pack_req(2, 5, {$urandom, $urandom}, $urandom, 8'h5a));
		put_request(OP_END, pack_req(1, 0, 0, 0, 0));
		put_request(OP_END, pack_req(1, 0, 0, 0, 0));
		put_request(OP_ENTRY, pack_req(15, 7, 7, 7, 7));
		put_request(OP_ENTRY, pack_req(0, 0, {$urandom, $urandom}, $urandom, 8'ha5));
		put_request(OP_END, pack_req(0, 0, 0, 0, 0));
		put_request(OP_END, pack_req(2, 0, 0, 0, 0));
		// zero run count behaves as one
		set_runs(0);
		put_request(OP_ENTRY, pack_req(1, 3, 3, 3, 3));
		put_request(OP_ENTRY, pack_req(0, 9, {$urandom, $urandom}, $urandom, 8'h81));
		// run count grown, then shrunk mid-merge; run 1 keeps its head until finish
		set_runs(3);
		put_request(OP_ENTRY, pack_req(1, 2, {$urandom, $urandom}, $urandom, 8'h18));
		set_runs(1);
		put_request(OP_END, pack_req(0, 0, 0, 0, 0));
		// later arrival on the lower run still wins the tie
		set_runs(2);
		put_request(OP_ENTRY, pack_req(1, 4, {$urandom, $urandom}, $urandom, 8'h42));
		put_request(OP_ENTRY, pack_req(0, 4, {$urandom, $urandom}, $urandom, 8'h24));

		// random merges in three idling phases; run count changes at merge boundaries
		for (int p = 0; p < 3; p++) begin
			phase       = p;
			src_idle    = (p == 0) ? 16 : (p == 1) ? 54 : 0;
			sink_idle   = (p == 0) ? 54 : (p == 1) ? 16 : 0;
			hold_from   = chk.requests + 20;
			cfg_due     = (p == 0) ? RUNS : (p == 1) ? 31 : 5;
			cfg_pending = 1'b1;
			for (int k = 0; k < PHASE_REQS; k++) begin
				make_request(op, w);
				put_request(op, w);
				if (chk.idle_merge()) begin
					reseed_keys();
					if (cfg_pending || $urandom_range(1)) begin
						set_runs(cfg_pending ? cfg_due : pick_runs());
						cfg_pending = 1'b0;
					end
				end
			end
		end

		settle();
		chk.close_out();
		if (chk.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sorted_run_kway_merger.f -----
+incdir+src
src/skm_pkg.sv
src/skm_ctrl.sv
src/skm_dpath.sv
src/sorted_run_kway_merger.sv
bench/tb.sv
